/* rtl/phe_pkg.sv */
// Shared types and constants for the Horner polynomial evaluator.
// No dependencies; used by every other file of the block.
package phe_pkg;

    localparam int DATA_W        = 32;
    localparam int REG_COUNT     = 8;
    localparam int IDX_W         = $clog2(REG_COUNT);
    localparam int ADDR_W        = IDX_W + 2;
    localparam int NUM_COEFS_DEF = 8;
    localparam int FRAC_BITS_DEF = 16;
    localparam int PROD_W        = 2 * DATA_W;

    typedef logic signed [DATA_W-1:0] data_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] x;
        logic signed [DATA_W-1:0] acc;
        logic                     sat;
    } phe_word_t;

endpackage

/* rtl/phe_regs.sv */
// APB register file holding the eight polynomial coefficients.
// Depends on phe_pkg.
module phe_regs (
    input  logic                                           aclk,
    input  logic                                           aresetn,
    input  logic                                           psel,
    input  logic                                           penable,
    input  logic                                           pwrite,
    input  logic [phe_pkg::ADDR_W-1:0]                     paddr,
    input  logic [phe_pkg::DATA_W-1:0]                     pwdata,
    output logic                                           pready,
    output logic [phe_pkg::DATA_W-1:0]                     prdata,
    output logic [phe_pkg::REG_COUNT-1:0][phe_pkg::DATA_W-1:0] coef
);
    import phe_pkg::*;

    logic [REG_COUNT-1:0][DATA_W-1:0] coef_reg;
    logic [IDX_W-1:0]                 idx;
    logic                             wr_en;

    assign idx    = paddr[ADDR_W-1:2];
    assign wr_en  = psel && penable && pwrite && pready;
    assign pready = 1'b1;
    assign prdata = coef_reg[idx];
    assign coef   = coef_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coef_reg <= '0;
        end else if (wr_en) begin
            coef_reg[idx] <= pwdata;
        end
    end

    a_write_lands: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |=> coef_reg[$past(idx)] == $past(pwdata))
        else $error("coefficient write not stored");

endmodule

/* rtl/phe_cell.sv */
// One Horner step: a multiply stage followed by a shift, add and saturate stage.
// Depends on phe_pkg.
module phe_cell #(
    parameter int FRAC_BITS = phe_pkg::FRAC_BITS_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  phe_pkg::phe_word_t        in_word,
    input  logic [phe_pkg::DATA_W-1:0] coef,
    output logic                      out_valid,
    input  logic                      out_ready,
    output phe_pkg::phe_word_t        out_word
);
    import phe_pkg::*;

    logic                     a_valid_reg;
    logic signed [DATA_W-1:0] a_x_reg;
    logic signed [PROD_W-1:0] a_prod_reg;
    logic                     a_sat_reg;
    logic signed [PROD_W-1:0] a_prod_next;

    logic                     b_valid_reg;
    phe_word_t                b_word_reg;
    phe_word_t                b_word_next;

    logic                     a_ready;
    logic                     b_ready;
    logic signed [PROD_W-1:0] sum;
    logic                     clip_hi;
    logic                     clip_lo;

    assign b_ready  = !b_valid_reg || out_ready;
    assign a_ready  = !a_valid_reg || b_ready;
    assign in_ready = a_ready;

    assign a_prod_next = PROD_W'($signed(in_word.x)) * PROD_W'($signed(in_word.acc));

    assign sum     = (a_prod_reg >>> FRAC_BITS) + PROD_W'($signed(coef));
    assign clip_hi = !sum[PROD_W-1] && (|sum[PROD_W-2:DATA_W-1]);
    assign clip_lo = sum[PROD_W-1] && !(&sum[PROD_W-2:DATA_W-1]);

    always_comb begin
        b_word_next.x   = a_x_reg;
        b_word_next.sat = a_sat_reg || clip_hi || clip_lo;
        if (clip_hi) begin
            b_word_next.acc = {1'b0, {(DATA_W-1){1'b1}}};
        end else if (clip_lo) begin
            b_word_next.acc = {1'b1, {(DATA_W-1){1'b0}}};
        end else begin
            b_word_next.acc = sum[DATA_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end else begin
            if (a_ready) begin
                a_valid_reg <= in_valid;
            end
            if (b_ready) begin
                b_valid_reg <= a_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (a_ready && in_valid) begin
            a_x_reg    <= in_word.x;
            a_prod_reg <= a_prod_next;
            a_sat_reg  <= in_word.sat;
        end
        if (b_ready && a_valid_reg) begin
            b_word_reg <= b_word_next;
        end
    end

    assign out_valid = b_valid_reg;
    assign out_word  = b_word_reg;

    a_hold_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid && !out_ready |=> out_valid && $stable(out_word))
        else $error("stalled word changed or vanished");

    a_no_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        a_valid_reg && b_ready |=> b_valid_reg)
        else $error("word lost between multiply and add stages");

    a_sat_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        a_valid_reg && b_ready && a_sat_reg |=> out_word.sat)
        else $error("saturation flag cleared by a later step");

endmodule

/* rtl/polynomial_horner_eval.sv */
// Horner polynomial evaluator: a chain of NUM_COEFS step cells, two stages each.
// Each x word passes through both registers of every cell in turn, multiply then add.
// Throughput is one word per cycle while m_ready is high; a stalled output holds the chain.
// Each cell's multiplier is registered before its add.
// Reset (synchronous, aresetn low) empties the chain and clears all coefficients.
// Depends on phe_pkg, phe_regs and phe_cell.
module polynomial_horner_eval #(
    parameter int NUM_COEFS = phe_pkg::NUM_COEFS_DEF,
    parameter int FRAC_BITS = phe_pkg::FRAC_BITS_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [phe_pkg::ADDR_W-1:0]  paddr,
    input  logic [phe_pkg::DATA_W-1:0]  pwdata,
    output logic                        pready,
    output logic [phe_pkg::DATA_W-1:0]  prdata,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic signed [phe_pkg::DATA_W-1:0] s_x_value,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic signed [phe_pkg::DATA_W-1:0] m_y_value,
    output logic                        m_saturated
);
    import phe_pkg::*;

    logic [REG_COUNT-1:0][DATA_W-1:0] coef;
    logic                             chain_valid [NUM_COEFS+1];
    logic                             chain_ready [NUM_COEFS+1];
    phe_word_t                        chain_word  [NUM_COEFS+1];

    phe_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .pready  (pready),
        .prdata  (prdata),
        .coef    (coef)
    );

    assign chain_valid[0]     = s_valid;
    assign s_ready            = chain_ready[0];
    assign chain_word[0].x    = s_x_value;
    assign chain_word[0].acc  = '0;
    assign chain_word[0].sat  = 1'b0;

    for (genvar j = 0; j < NUM_COEFS; j++) begin : g_cell
        phe_cell #(
            .FRAC_BITS (FRAC_BITS)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (chain_valid[j]),
            .in_ready  (chain_ready[j]),
            .in_word   (chain_word[j]),
            .coef      (coef[NUM_COEFS-1-j]),
            .out_valid (chain_valid[j+1]),
            .out_ready (chain_ready[j+1]),
            .out_word  (chain_word[j+1])
        );
    end

    assign m_valid                = chain_valid[NUM_COEFS];
    assign chain_ready[NUM_COEFS] = m_ready;
    assign m_y_value              = chain_word[NUM_COEFS].acc;
    assign m_saturated            = chain_word[NUM_COEFS].sat;

endmodule

/* test/polynomial_horner_eval_test.sv */
// Self-checking testbench for polynomial_horner_eval: x words in, y words out.
// Holds its own Horner predictor in signed fixed point and checks every result word.
// Depends on phe_pkg and the polynomial_horner_eval RTL.
`timescale 1ns / 100ps

module polynomial_horner_eval_test;

    import phe_pkg::*;

    localparam int NUM_COEFS      = NUM_COEFS_DEF;
    localparam int FRAC_BITS      = FRAC_BITS_DEF;
    localparam int REG_STRIDE     = 4;
    localparam int RAND_PHASES    = 7;
    localparam int RAND_PER_PHASE = 200;
    localparam int MAX_REPORTS    = 10;
    localparam longint SUM_MAX    = 64'sd2147483647;
    localparam longint SUM_MIN    = -64'sd2147483648;
    localparam data_t X_MAX       = 32'sh7FFF_FFFF;
    localparam data_t X_MIN       = 32'sh8000_0000;
    localparam data_t ONE_Q       = 32'sh0001_0000;

    typedef enum logic {CHK_MODEL, CHK_TYPED} check_t;
    typedef enum logic [2:0] {
        SET_ZERO, SET_C0_MAX, SET_C0_MIN, SET_ALL_MAX, SET_CUBIC, SET_STRIPES
    } coef_set_t;

    typedef struct packed {
        data_t y;
        logic  sat;
    } y_word_t;

    typedef struct packed {
        coef_set_t cset;
        data_t     x;
        check_t    kind;
        data_t     y;
        logic      sat;
    } probe_t;

    logic              aclk        = 1'b0;
    logic              aresetn     = 1'b0;
    logic              psel        = 1'b0;
    logic              penable     = 1'b0;
    logic              pwrite      = 1'b0;
    logic [ADDR_W-1:0] paddr       = '0;
    logic [DATA_W-1:0] pwdata      = '0;
    logic              pready;
    logic [DATA_W-1:0] prdata;
    logic              s_valid     = 1'b0;
    logic              s_ready;
    data_t             s_x_value   = '0;
    logic              m_valid;
    logic              m_ready     = 1'b0;
    data_t             m_y_value;
    logic              m_saturated;

    data_t       coef_shadow [REG_COUNT];
    data_t       coef_next [REG_COUNT];
    y_word_t     pending_y [$];
    probe_t      probe_table [$];
    int unsigned burst_left  = 0;
    int unsigned ready_left  = 0;
    int unsigned ready_pct   = 100;
    int unsigned n_sent      = 0;
    int unsigned n_checked   = 0;
    int unsigned n_saturated = 0;
    int unsigned n_mismatch  = 0;
    int unsigned n_settings  = 0;

    polynomial_horner_eval #(
        .NUM_COEFS(NUM_COEFS),
        .FRAC_BITS(FRAC_BITS)
    ) dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .pready     (pready),
        .prdata     (prdata),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_x_value  (s_x_value),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_y_value  (m_y_value),
        .m_saturated(m_saturated)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    initial begin
        #2_000_000;
        $display("FAIL");
        $finish;
    end

    // Horner's scheme from the top coefficient down, clipping each partial sum.
    function automatic y_word_t horner_eval(input data_t x);
        longint  acc;
        longint  sum;
        y_word_t w;
        acc   = 0;
        w.sat = 1'b0;
        for (int k = NUM_COEFS - 1; k >= 0; k--) begin
            sum = ((longint'(x) * acc) >>> FRAC_BITS) + longint'(coef_shadow[k]);
            if (sum > SUM_MAX) begin
                sum   = SUM_MAX;
                w.sat = 1'b1;
            end else if (sum < SUM_MIN) begin
                sum   = SUM_MIN;
                w.sat = 1'b1;
            end
            acc = sum;
        end
        w.y = data_t'(acc);
        return w;
    endfunction

    function automatic void add_probe(input coef_set_t cset, input data_t x,
                                      input check_t kind, input data_t y, input logic sat);
        probe_t p;
        p.cset = cset;
        p.x    = x;
        p.kind = kind;
        p.y    = y;
        p.sat  = sat;
        probe_table.insert(probe_table.size(), p);
    endfunction

    task automatic stage_set(input coef_set_t cset);
        for (int k = 0; k < REG_COUNT; k++) begin
            coef_next[k] = '0;
        end
        case (cset)
            SET_C0_MAX: begin
                coef_next[0] = X_MAX;
            end
            SET_C0_MIN: begin
                coef_next[0] = X_MIN;
            end
            SET_ALL_MAX: begin
                for (int k = 0; k < REG_COUNT; k++) coef_next[k] = X_MAX;
            end
            SET_CUBIC: begin
                coef_next[0] = ONE_Q;
                coef_next[1] = 32'shFFFE_0000;
                coef_next[2] = 32'sh0000_8000;
                coef_next[3] = 32'sh0000_0001;
            end
            SET_STRIPES: begin
                for (int k = 0; k < REG_COUNT; k++) begin
                    coef_next[k] = k[0] ? 32'sh5555_5555 : 32'shAAAA_AAAA;
                end
            end
            default: begin
            end
        endcase
    endtask

    task automatic pace_sender();
        int unsigned gap;
        if (burst_left != 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    endtask

    task automatic send_x(input data_t x, input check_t kind, input data_t y, input logic sat);
        y_word_t w;
        s_valid   <= 1'b1;
        s_x_value <= x;
        do @(posedge aclk); while (!s_ready);
        if (kind == CHK_TYPED) begin
            w.y   = y;
            w.sat = sat;
        end else begin
            w = horner_eval(x);
        end
        pending_y.insert(pending_y.size(), w);
        n_sent++;
        pace_sender();
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (pending_y.size() != 0) @(posedge aclk);
    endtask

    task automatic write_coef(input int unsigned idx, input data_t value);
        logic [ADDR_W-1:0] addr;
        addr = ADDR_W'(idx * REG_STRIDE);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        coef_shadow[idx] = value;
    endtask

    task automatic apply_coefs();
        wait_drained();
        for (int k = 0; k < REG_COUNT; k++) begin
            write_coef(k, coef_next[k]);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
        n_settings++;
    endtask

    // The receiver changes its appetite at random intervals, from never stalling to mostly stalled.
    always @(posedge aclk) begin
        if (ready_left == 0) begin
            ready_left = $urandom_range(16, 96);
            case ($urandom_range(0, 3))
                0: ready_pct = 100;
                1: ready_pct = 80;
                2: ready_pct = 50;
                default: ready_pct = 15;
            endcase
        end else begin
            ready_left--;
        end
        m_ready <= ($urandom_range(0, 99) < ready_pct);
    end

    always @(posedge aclk) begin
        y_word_t w;
        if (aresetn && m_valid && m_ready) begin
            if (pending_y.size() == 0) begin
                n_mismatch++;
                if (n_mismatch <= MAX_REPORTS) begin
                    $display("unexpected result word: y %h sat %b", m_y_value, m_saturated);
                end
            end else begin
                w = pending_y.pop_front();
                n_checked++;
                if (m_saturated === 1'b1) n_saturated++;
                if (m_y_value !== w.y || m_saturated !== w.sat) begin
                    n_mismatch++;
                    if (n_mismatch <= MAX_REPORTS) begin
                        $display("mismatch on word %0d: expected y %h sat %b, got y %h sat %b",
                                 n_checked, w.y, w.sat, m_y_value, m_saturated);
                    end
                end
            end
        end
    end

    initial begin
        probe_t      p;
        coef_set_t   cur_set;
        data_t       x;
        int unsigned degree;
        int unsigned roll;

        for (int k = 0; k < REG_COUNT; k++) begin
            coef_shadow[k] = '0;
        end

        // All coefficients are zero out of reset, so anything gives zero.
        add_probe(SET_ZERO, 32'sh0, CHK_TYPED, 32'sh0, 1'b0);
        add_probe(SET_ZERO, X_MAX, CHK_TYPED, 32'sh0, 1'b0);
        add_probe(SET_ZERO, X_MIN, CHK_TYPED, 32'sh0, 1'b0);
        add_probe(SET_ZERO, ONE_Q, CHK_TYPED, 32'sh0, 1'b0);
        add_probe(SET_ZERO, -32'sh1, CHK_TYPED, 32'sh0, 1'b0);
        add_probe(SET_C0_MAX, X_MIN, CHK_TYPED, X_MAX, 1'b0);
        add_probe(SET_C0_MAX, X_MAX, CHK_TYPED, X_MAX, 1'b0);
        add_probe(SET_C0_MAX, 32'sh0, CHK_TYPED, X_MAX, 1'b0);
        add_probe(SET_C0_MIN, X_MAX, CHK_TYPED, X_MIN, 1'b0);
        add_probe(SET_C0_MIN, -ONE_Q, CHK_TYPED, X_MIN, 1'b0);
        // With every coefficient at its maximum the partial sums clip for extreme x, but not for x of zero.
        add_probe(SET_ALL_MAX, X_MAX, CHK_TYPED, X_MAX, 1'b1);
        add_probe(SET_ALL_MAX, X_MIN, CHK_TYPED, X_MIN, 1'b1);
        add_probe(SET_ALL_MAX, 32'sh0, CHK_TYPED, X_MAX, 1'b0);
        add_probe(SET_ALL_MAX, 32'sh1, CHK_MODEL, '0, 1'b0);
        add_probe(SET_CUBIC, ONE_Q, CHK_MODEL, '0, 1'b0);
        add_probe(SET_CUBIC, 32'sh0002_0000, CHK_MODEL, '0, 1'b0);
        add_probe(SET_CUBIC, -32'sh0000_8000, CHK_MODEL, '0, 1'b0);
        add_probe(SET_CUBIC, -32'sh1, CHK_MODEL, '0, 1'b0);
        add_probe(SET_CUBIC, X_MAX, CHK_MODEL, '0, 1'b0);
        add_probe(SET_CUBIC, X_MIN, CHK_MODEL, '0, 1'b0);
        add_probe(SET_STRIPES, 32'shAAAA_AAAA, CHK_MODEL, '0, 1'b0);
        add_probe(SET_STRIPES, 32'sh5555_5555, CHK_MODEL, '0, 1'b0);
        add_probe(SET_STRIPES, 32'sh0000_0100, CHK_MODEL, '0, 1'b0);

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        cur_set = SET_ZERO;
        foreach (probe_table[i]) begin
            p = probe_table[i];
            if (p.cset != cur_set) begin
                stage_set(p.cset);
                apply_coefs();
                cur_set = p.cset;
            end
            send_x(p.x, p.kind, p.y, p.sat);
        end

        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            degree = (ph == RAND_PHASES - 1) ? NUM_COEFS - 1 : $urandom_range(0, NUM_COEFS - 1);
            for (int k = 0; k < REG_COUNT; k++) begin
                roll = $urandom_range(0, 19);
                if (k > degree) begin
                    coef_next[k] = '0;
                end else if (roll < 10) begin
                    coef_next[k] = $urandom_range(0, 32'h0008_0000);
                    coef_next[k] = coef_next[k] - 32'sh0004_0000;
                end else if (roll < 17) begin
                    coef_next[k] = $urandom;
                end else begin
                    case ($urandom_range(0, 3))
                        0: coef_next[k] = X_MAX;
                        1: coef_next[k] = X_MIN;
                        2: coef_next[k] = 32'sh1;
                        default: coef_next[k] = -32'sh1;
                    endcase
                end
            end
            apply_coefs();
            for (int n = 0; n < RAND_PER_PHASE; n++) begin
                roll = $urandom_range(0, 19);
                if (roll < 8) begin
                    x = $urandom_range(0, 32'h0008_0000);
                    x = x - 32'sh0004_0000;
                end else if (roll < 11) begin
                    x = $urandom_range(0, 512);
                    x = x - 32'sh100;
                end else if (roll < 17) begin
                    x = $urandom;
                end else begin
                    case ($urandom_range(0, 6))
                        0: x = X_MAX;
                        1: x = X_MIN;
                        2: x = 32'sh0;
                        3: x = 32'sh1;
                        4: x = -32'sh1;
                        5: x = ONE_Q;
                        default: x = -ONE_Q;
                    endcase
                end
                send_x(x, CHK_MODEL, '0, 1'b0);
            end
        end

        wait_drained();
        repeat (2 * NUM_COEFS + 8) @(posedge aclk);

        $display("Sent %0d x words under %0d coefficient settings written over the register port.",
                 n_sent, n_settings);
        $display("Checked %0d result words, %0d of them saturated; %0d mismatches.",
                 n_checked, n_saturated, n_mismatch);
        if (n_mismatch == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
